[hdl/feistel_block_cipher_64_macros.svh]
// assertion helpers, included by the cipher top level
`ifndef FEISTEL_BLOCK_CIPHER_64_MACROS_SVH
`define FEISTEL_BLOCK_CIPHER_64_MACROS_SVH

// same-cycle implication, checked outside reset
`define FBC_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FBC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hdl/fbc64_pkg.sv]
`timescale 1ns / 1ps

package fbc64_pkg;

    localparam int ROUND_COUNT = 16;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // one pipeline slot
    typedef struct packed {
        logic        valid;
        logic        command;
        logic [31:0] left;
        logic [31:0] right;
    } t_stage;

    // bit i of the expanded word is bit EXT_MAP[i] of the right half
    localparam logic [4:0] EXT_MAP [64] = '{
        5'd27, 5'd28, 5'd29, 5'd30, 5'd31, 5'd0,  5'd1,  5'd2,
        5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,
        5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
        5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
        5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30,
        5'd31, 5'd0,  5'd1,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,
        5'd8,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd17,
        5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd24, 5'd25, 5'd26
    };

    // [box][row][column]
    localparam logic [1:0] SBOXES [16][4][4] = '{
        '{'{2'd0,2'd3,2'd1,2'd2}, '{2'd3,2'd2,2'd1,2'd0},
          '{2'd1,2'd2,2'd0,2'd3}, '{2'd1,2'd2,2'd3,2'd0}},
        '{'{2'd0,2'd1,2'd3,2'd2}, '{2'd1,2'd3,2'd0,2'd2},
          '{2'd2,2'd1,2'd0,2'd3}, '{2'd3,2'd2,2'd0,2'd1}},
        '{'{2'd2,2'd0,2'd3,2'd1}, '{2'd2,2'd0,2'd1,2'd3},
          '{2'd1,2'd3,2'd2,2'd0}, '{2'd3,2'd1,2'd2,2'd0}},
        '{'{2'd3,2'd1,2'd0,2'd2}, '{2'd3,2'd0,2'd2,2'd1},
          '{2'd2,2'd3,2'd1,2'd0}, '{2'd2,2'd3,2'd0,2'd1}},
        '{'{2'd2,2'd3,2'd1,2'd0}, '{2'd2,2'd1,2'd0,2'd3},
          '{2'd0,2'd1,2'd2,2'd3}, '{2'd0,2'd2,2'd3,2'd1}},
        '{'{2'd0,2'd3,2'd2,2'd1}, '{2'd0,2'd1,2'd2,2'd3},
          '{2'd0,2'd2,2'd1,2'd3}, '{2'd2,2'd1,2'd0,2'd3}},
        '{'{2'd3,2'd2,2'd1,2'd0}, '{2'd2,2'd1,2'd0,2'd3},
          '{2'd1,2'd2,2'd0,2'd3}, '{2'd1,2'd3,2'd0,2'd2}},
        '{'{2'd0,2'd3,2'd1,2'd2}, '{2'd1,2'd2,2'd0,2'd3},
          '{2'd2,2'd3,2'd1,2'd0}, '{2'd3,2'd0,2'd1,2'd2}},
        '{'{2'd2,2'd1,2'd0,2'd3}, '{2'd2,2'd0,2'd1,2'd3},
          '{2'd1,2'd2,2'd0,2'd3}, '{2'd3,2'd2,2'd0,2'd1}},
        '{'{2'd0,2'd3,2'd1,2'd2}, '{2'd2,2'd3,2'd0,2'd1},
          '{2'd2,2'd0,2'd1,2'd3}, '{2'd1,2'd3,2'd2,2'd0}},
        '{'{2'd3,2'd1,2'd2,2'd0}, '{2'd3,2'd0,2'd2,2'd1},
          '{2'd1,2'd0,2'd2,2'd3}, '{2'd0,2'd2,2'd1,2'd3}},
        '{'{2'd0,2'd3,2'd1,2'd2}, '{2'd2,2'd1,2'd0,2'd3},
          '{2'd1,2'd2,2'd3,2'd0}, '{2'd0,2'd2,2'd3,2'd1}},
        '{'{2'd3,2'd0,2'd2,2'd1}, '{2'd0,2'd3,2'd1,2'd2},
          '{2'd1,2'd0,2'd3,2'd2}, '{2'd1,2'd3,2'd0,2'd2}},
        '{'{2'd1,2'd2,2'd3,2'd0}, '{2'd2,2'd3,2'd0,2'd1},
          '{2'd2,2'd0,2'd1,2'd3}, '{2'd0,2'd3,2'd1,2'd2}},
        '{'{2'd1,2'd2,2'd0,2'd3}, '{2'd2,2'd3,2'd1,2'd0},
          '{2'd3,2'd1,2'd0,2'd2}, '{2'd0,2'd2,2'd3,2'd1}},
        '{'{2'd1,2'd0,2'd3,2'd2}, '{2'd3,2'd1,2'd2,2'd0},
          '{2'd3,2'd0,2'd1,2'd2}, '{2'd0,2'd2,2'd3,2'd1}}
    };

    // expansion, key mix and s-box layer
    function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [63:0] key);
        logic [63:0] w;
        logic [31:0] f;
        logic [3:0]  nib;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [1:0]  s;
        for (int i = 0; i < 64; i++) begin
            w[i] = r[EXT_MAP[i]];
        end
        w = w ^ key;
        for (int g = 0; g < 16; g++) begin
            nib        = w[4*g +: 4];
            row        = {nib[2], nib[0]};
            col        = {nib[3], nib[1]};
            s          = SBOXES[g][row][col];
            f[2*g]     = s[1];
            f[2*g + 1] = s[0];
        end
        return f;
    endfunction

endpackage

[hdl/fbc64_in_if.sv]
`timescale 1ns / 1ps

interface fbc64_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] left_in;
    logic [31:0] right_in;

    modport source (output valid, output command, output left_in, output right_in,
                    input ready);
    modport sink   (input valid, input command, input left_in, input right_in,
                    output ready);
endinterface

[hdl/fbc64_out_if.sv]
`timescale 1ns / 1ps

interface fbc64_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_out;
    logic [31:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

[hdl/fbc64_round.sv]
`timescale 1ns / 1ps

// one feistel round with its pipeline register
module fbc64_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [63:0]         i_key,
    input  fbc64_pkg::t_stage   i_stage,
    output fbc64_pkg::t_stage   o_stage
);

    logic        r_valid;
    logic        r_command;
    logic [31:0] r_left;
    logic [31:0] r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_command <= i_stage.command;
            r_left    <= i_stage.right;
            r_right   <= i_stage.left ^ fbc64_pkg::round_fn(i_stage.right, i_key);
        end
    end

    assign o_stage = '{valid: r_valid, command: r_command, left: r_left, right: r_right};

endmodule

[hdl/feistel_block_cipher_64.sv]
`timescale 1ns / 1ps

// 64-bit feistel block cipher, ROUND_COUNT rounds with the same 64-bit key in each.
// a request carries a command (0 encrypt, 1 decrypt) and the left and right halves;
// every request gives exactly one response, in order. one round per pipeline stage,
// so a new block is taken every cycle while the skid slot is empty. a one-entry skid
// register behind the last round lets the pipeline take one more request after the
// output stalls; input ready then drops until the skid entry is taken. write the key
// only while no block is in flight.
module feistel_block_cipher_64 #(
    parameter int ROUND_COUNT = fbc64_pkg::ROUND_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [63:0]       i_cfg_wdata,
    fbc64_in_if.sink          i_req,
    fbc64_out_if.source       o_rsp
);

`include "feistel_block_cipher_64_macros.svh"

    // key register
    logic [63:0] r_cipher_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (i_cfg_we) begin
            r_cipher_key <= i_cfg_wdata;
        end
    end

    // pipeline advances as long as the skid slot is free
    logic w_adv;
    logic r_skid_v;

    assign w_adv       = !r_skid_v;
    assign i_req.ready = w_adv;

    // stage 0 is the incoming request; decrypt swaps halves on the way in
    fbc64_pkg::t_stage w_stage [ROUND_COUNT + 1];
    logic [ROUND_COUNT:1] w_vld;

    always_comb begin
        w_stage[0].valid   = i_req.valid;
        w_stage[0].command = i_req.command;
        if (i_req.command == fbc64_pkg::CMD_DECRYPT) begin
            w_stage[0].left  = i_req.right_in;
            w_stage[0].right = i_req.left_in;
        end else begin
            w_stage[0].left  = i_req.left_in;
            w_stage[0].right = i_req.right_in;
        end
    end

    // round pipeline
    for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
        fbc64_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_key   (r_cipher_key),
            .i_stage (w_stage[k]),
            .o_stage (w_stage[k + 1])
        );
    end

    for (genvar k = 1; k <= ROUND_COUNT; k++) begin : g_vld
        assign w_vld[k] = w_stage[k].valid;
    end

    // last round output, decrypt swaps halves back
    logic [31:0] w_last_left;
    logic [31:0] w_last_right;
    logic        w_last_v;

    assign w_last_v = w_stage[ROUND_COUNT].valid;

    always_comb begin
        if (w_stage[ROUND_COUNT].command == fbc64_pkg::CMD_DECRYPT) begin
            w_last_left  = w_stage[ROUND_COUNT].right;
            w_last_right = w_stage[ROUND_COUNT].left;
        end else begin
            w_last_left  = w_stage[ROUND_COUNT].left;
            w_last_right = w_stage[ROUND_COUNT].right;
        end
    end

    // skid slot: catches the last stage when the output stalls
    logic        n_skid_v;
    logic [31:0] r_skid_left;
    logic [31:0] r_skid_right;

    always_comb begin
        if (r_skid_v) begin
            n_skid_v = !o_rsp.ready;
        end else begin
            n_skid_v = w_last_v && !o_rsp.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else begin
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_left  <= w_last_left;
            r_skid_right <= w_last_right;
        end
    end

    // response: skid entry first, otherwise the last stage directly
    assign o_rsp.valid     = r_skid_v || w_last_v;
    assign o_rsp.left_out  = r_skid_v ? r_skid_left  : w_last_left;
    assign o_rsp.right_out = r_skid_v ? r_skid_right : w_last_right;

    // checks
    `FBC_ASSERT_NOW(a_skid_blocks_req, i_clk, i_rst_n, r_skid_v, !i_req.ready, "request taken with skid full")
    `FBC_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, !r_skid_v && w_last_v && !o_rsp.ready, r_skid_v, "stalled result not caught")
    `FBC_ASSERT_NEXT(a_pipe_holds, i_clk, i_rst_n, r_skid_v, $stable(w_vld), "pipeline moved while skid full")

endmodule
